// File: rtl/tdpa_pkg.sv
package tdpa_pkg;

   // defaults for the top-level parameters
   localparam int SPEED_WIDTH_DEF = 16;
   localparam int TIME_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 8;

   // fixed result field widths
   localparam int DIST_W     = 56;
   localparam int PEAK_W     = 24;
   localparam int RSP_DATA_W = ((DIST_W + PEAK_W + 7) / 8) * 8;

   // serial multiply / divide core status
   typedef struct packed {
      logic done;
   } md_status_type;

endpackage

// File: rtl/tdpa_mul_div.sv
// Bit-serial shift-add multiplier and restoring divider, run side by side.
module tdpa_mul_div #(
   parameter int SPEED_WIDTH = tdpa_pkg::SPEED_WIDTH_DEF,
   parameter int TIME_WIDTH  = tdpa_pkg::TIME_WIDTH_DEF,
   parameter int FRAC_BITS   = tdpa_pkg::FRAC_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   input  logic [SPEED_WIDTH:0]                     sum_mag,
   input  logic [SPEED_WIDTH:0]                     dv_mag,
   input  logic [TIME_WIDTH-1:0]                    dt,
   output logic [SPEED_WIDTH+1+TIME_WIDTH-1:0]      prod,
   output logic [((SPEED_WIDTH+1+FRAC_BITS) > tdpa_pkg::PEAK_W ?
                  (SPEED_WIDTH+1+FRAC_BITS) : tdpa_pkg::PEAK_W+1)-1:0] quo,
   output tdpa_pkg::md_status_type                  status
);
   import tdpa_pkg::*;

   localparam int MAG_W  = SPEED_WIDTH + 1;
   localparam int PROD_W = MAG_W + TIME_WIDTH;
   localparam int DIVD_W = MAG_W + FRAC_BITS;
   localparam int QUO_W  = (DIVD_W > PEAK_W) ? DIVD_W : PEAK_W + 1;
   localparam int STEPS  = (TIME_WIDTH > QUO_W) ? TIME_WIDTH : QUO_W;
   localparam int CNT_W  = $clog2(STEPS + 1);

   logic                  run_ff, run_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [MAG_W-1:0]      mag_ff, mag_in;
   logic [TIME_WIDTH-1:0] dt_ff, dt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [QUO_W-1:0]      divd_ff, divd_in;
   logic [TIME_WIDTH-1:0] rem_ff, rem_in;

   logic [MAG_W:0]        mul_sum;
   logic [TIME_WIDTH:0]   trial;
   logic                  q_bit;
   logic                  last_step;

   assign last_step = run_ff && (cnt_ff == CNT_W'(STEPS - 1));

   always_comb begin
      // multiplier: add on multiplier LSB, shift right
      mul_sum = {1'b0, prod_ff[PROD_W-1:TIME_WIDTH]} +
                {1'b0, (prod_ff[0] ? mag_ff : MAG_W'(0))};
      // divider: one quotient bit per step, MSB first
      trial   = {rem_ff, divd_ff[QUO_W-1]};
      q_bit   = (trial >= {1'b0, dt_ff});

      run_in  = run_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      dt_in   = dt_ff;
      prod_in = prod_ff;
      divd_in = divd_ff;
      rem_in  = rem_ff;

      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         mag_in  = sum_mag;
         dt_in   = dt;
         prod_in = {MAG_W'(0), dt};
         divd_in = QUO_W'(dv_mag) << FRAC_BITS;
         rem_in  = '0;
      end else if (run_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            run_in = 1'b0;
         end
         if (cnt_ff < CNT_W'(TIME_WIDTH)) begin
            prod_in = {mul_sum, prod_ff[TIME_WIDTH-1:1]};
         end
         if (cnt_ff < CNT_W'(QUO_W)) begin
            divd_in = {divd_ff[QUO_W-2:0], q_bit};
            rem_in  = q_bit ? TIME_WIDTH'(trial - {1'b0, dt_ff})
                            : trial[TIME_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
      mag_ff  <= mag_in;
      dt_ff   <= dt_in;
      prod_ff <= prod_in;
      divd_ff <= divd_in;
      rem_ff  <= rem_in;
   end

   assign prod        = prod_ff;
   assign quo         = divd_ff;
   assign status.done = last_step;

endmodule

// File: rtl/trapezoid_distance_peak_accel_unit.sv
// Channel   Dir  Fields (tdata/tuser, lowest bit first)
// req_      in   tuser: start_run; tdata: speed_sample, sample_time
// rsp_      out  tdata: distance_total, peak_accel; tuser: zero_interval
//
// A start sample (or the first one after reset) goes from IDLE straight to FIN, which
// registers its result and frees the input together. Any other sample waits in RUN
// while the bit-serial multiply and divide in tdpa_mul_div run in parallel one bit
// per cycle, then goes to FIN, which registers its result and frees the input.
// One sample is in work at a time; the next is taken while a result waits.
// Reset is synchronous; it clears the run state, the previous sample and totals.
// A stalled result holds rsp_ and the last step waits until the register frees.
module trapezoid_distance_peak_accel_unit #(
   parameter int SPEED_WIDTH = tdpa_pkg::SPEED_WIDTH_DEF,
   parameter int TIME_WIDTH  = tdpa_pkg::TIME_WIDTH_DEF,
   parameter int FRAC_BITS   = tdpa_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // speed_sample, sample_time, zero fill
   input  logic [((SPEED_WIDTH+TIME_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                                  req_tuser,   // start_run
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // distance_total, peak_accel
   output logic [tdpa_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser    // zero_interval
);
   import tdpa_pkg::*;

   localparam int MAG_W  = SPEED_WIDTH + 1;
   localparam int PROD_W = MAG_W + TIME_WIDTH;
   localparam int DIVD_W = MAG_W + FRAC_BITS;
   localparam int QUO_W  = (DIVD_W > PEAK_W) ? DIVD_W : PEAK_W + 1;
   localparam int SUM_W  = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 2;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
   localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
   localparam logic [PEAK_W-1:0]        PEAK_MAX = '1;

   // control
   logic [1:0]                    state_ff, state_in;
   logic                          have_prev_ff, have_prev_in;
   logic                          first_ff, first_in;
   logic                          neg_ff, neg_in;
   logic                          zero_ff, zero_in;
   // run state
   logic signed [SPEED_WIDTH-1:0] last_speed_ff, last_speed_in;
   logic [TIME_WIDTH-1:0]         last_time_ff, last_time_in;
   logic signed [DIST_W-1:0]      dist_ff, dist_in;
   logic [PEAK_W-1:0]             peak_ff, peak_in;
   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]             rsp_dist_ff, rsp_dist_in;
   logic [PEAK_W-1:0]             rsp_peak_ff, rsp_peak_in;
   logic                          rsp_zero_ff, rsp_zero_in;

   logic                          req_xfer;
   logic signed [SPEED_WIDTH-1:0] in_speed;
   logic [TIME_WIDTH-1:0]         in_time;
   logic [TIME_WIDTH-1:0]         dt;
   logic signed [MAG_W-1:0]       sum_s, dv_s;
   logic [MAG_W-1:0]              sum_mag, dv_mag;
   logic                          md_start;
   logic [PROD_W-1:0]             prod;
   logic [QUO_W-1:0]              quo;
   md_status_type                 md_status;

   logic [PROD_W:0]               half;
   logic signed [SUM_W-1:0]       area, total;
   logic signed [DIST_W-1:0]      dist_upd;
   logic [PEAK_W-1:0]             accel, peak_upd;
   logic                          rsp_free;

   assign in_speed = req_tdata[SPEED_WIDTH-1:0];
   assign in_time  = req_tdata[SPEED_WIDTH+TIME_WIDTH-1:SPEED_WIDTH];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      dt      = in_time - last_time_ff;
      sum_s   = MAG_W'(last_speed_ff) + MAG_W'(in_speed);
      dv_s    = MAG_W'(in_speed) - MAG_W'(last_speed_ff);
      sum_mag = sum_s[MAG_W-1] ? MAG_W'(-sum_s) : MAG_W'(sum_s);
      dv_mag  = dv_s[MAG_W-1] ? MAG_W'(-dv_s) : MAG_W'(dv_s);
   end

   assign md_start = req_xfer && !req_tuser && have_prev_ff;

   tdpa_mul_div #(
      .SPEED_WIDTH (SPEED_WIDTH),
      .TIME_WIDTH  (TIME_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_mul_div (
      .clock   (clock),
      .reset   (reset),
      .start   (md_start),
      .sum_mag (sum_mag),
      .dv_mag  (dv_mag),
      .dt      (dt),
      .prod    (prod),
      .quo     (quo),
      .status  (md_status)
   );

   // trapezoid: halve, rounding toward minus infinity, then saturating add
   always_comb begin
      half  = ({1'b0, prod} + (PROD_W+1)'(neg_ff)) >> 1;
      area  = neg_ff ? -$signed(SUM_W'(half)) : $signed(SUM_W'(half));
      total = SUM_W'(dist_ff) + area;
      if (total > SUM_W'(DIST_MAX)) begin
         dist_upd = DIST_MAX;
      end else if (total < SUM_W'(DIST_MIN)) begin
         dist_upd = DIST_MIN;
      end else begin
         dist_upd = total[DIST_W-1:0];
      end
      if (zero_ff || (quo > QUO_W'(PEAK_MAX))) begin
         accel = PEAK_MAX;
      end else begin
         accel = quo[PEAK_W-1:0];
      end
      peak_upd = (accel > peak_ff) ? accel : peak_ff;
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      first_in      = first_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      last_speed_in = last_speed_ff;
      last_time_in  = last_time_ff;
      dist_in       = dist_ff;
      peak_in       = peak_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_dist_in   = rsp_dist_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_zero_in   = rsp_zero_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               last_speed_in = in_speed;
               last_time_in  = in_time;
               have_prev_in  = 1'b1;
               if (req_tuser || !have_prev_ff) begin
                  // new run: totals cleared, no area, no acceleration
                  first_in = 1'b1;
                  zero_in  = 1'b0;
                  dist_in  = '0;
                  peak_in  = '0;
                  state_in = ST_FIN;
               end else begin
                  first_in = 1'b0;
                  neg_in   = sum_s[MAG_W-1];
                  zero_in  = (dt == '0);
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (md_status.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_zero_in  = zero_ff;
               if (first_ff) begin
                  rsp_dist_in = dist_ff;
                  rsp_peak_in = peak_ff;
               end else begin
                  dist_in     = dist_upd;
                  peak_in     = peak_upd;
                  rsp_dist_in = dist_upd;
                  rsp_peak_in = peak_upd;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         have_prev_ff  <= 1'b0;
         first_ff      <= 1'b0;
         zero_ff       <= 1'b0;
         last_speed_ff <= '0;
         last_time_ff  <= '0;
         dist_ff       <= '0;
         peak_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         first_ff      <= first_in;
         zero_ff       <= zero_in;
         last_speed_ff <= last_speed_in;
         last_time_ff  <= last_time_in;
         dist_ff       <= dist_in;
         peak_ff       <= peak_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_peak_ff, rsp_dist_ff});
   assign rsp_tuser  = rsp_zero_ff;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   import tdpa_pkg::*;

   localparam int SPEED_W    = SPEED_WIDTH_DEF;
   localparam int TIME_W     = TIME_WIDTH_DEF;
   localparam int FRAC_W     = FRAC_BITS_DEF;
   localparam int REQ_DATA_W = ((SPEED_W + TIME_W + 7) / 8) * 8;

   // saturation bounds of the distance accumulator and the acceleration
   localparam longint signed   DIST_MAX  = 64'sh007F_FFFF_FFFF_FFFF;
   localparam longint signed   DIST_MIN  = -DIST_MAX - 1;
   localparam longint unsigned ACCEL_MAX = 64'h0000_0000_00FF_FFFF;

   localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer
   localparam int RX_HOLD_CYCLES = 600;   // long receiver hold-off to back up the block
   localparam int RX_HOLD_AT     = 30;    // result count that triggers it
   localparam int TAIL_ITEMS     = 60;    // no idling over the last items
   localparam int SAT_RUN_LEN    = 272;   // enough full-scale samples to hit the bound

   typedef struct {
      bit                          start;
      logic signed [SPEED_W-1:0]   speed;
      logic        [TIME_W-1:0]    stamp;
      bit                          drain_first;  // sender waits for all results first
   } speed_sample_type;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic [PEAK_W-1:0] peak;
      logic              zero_int;
   } trip_totals_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;     // speed_sample, sample_time
   logic                  req_tuser  = 1'b0;   // start_run
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;           // distance_total, peak_accel
   logic                  rsp_tuser;           // zero_interval

   trapezoid_distance_peak_accel_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // stimulus and expectations
   speed_sample_type pending_samples[$];
   trip_totals_type  expected_totals[$];
   speed_sample_type offered;
   trip_totals_type  want;

   int samples_taken = 0;
   int results_seen  = 0;
   int error_count   = 0;
   int total_samples = 0;
   int quiet_from    = 0;
   int quiet_cycles  = 0;
   int send_gap      = 0;
   int recv_gap      = 0;
   int hold_left     = 0;

   // predictor state: previous sample and running totals of the current trip
   logic signed [SPEED_W-1:0] prev_speed;
   logic        [TIME_W-1:0]  prev_stamp;
   longint signed             dist_acc;
   longint unsigned           peak_hold;
   bit                        trip_open;

   // stimulus builder state
   logic        [TIME_W-1:0]  stamp_now;
   logic signed [SPEED_W-1:0] speed_now;

   // One accepted sample in, its totals out; updates the predictor state.
   function automatic trip_totals_type advance_trip(input speed_sample_type s);
      logic [TIME_W-1:0] dt32;
      longint unsigned   dt, mag, prod, half, dvmag, accel;
      longint signed     sum_v, dv, area;
      bit                neg;
      trip_totals_type   r;
      r.zero_int = 1'b0;
      if (s.start || !trip_open) begin
         dist_acc  = 0;
         peak_hold = 0;
      end else begin
         dt32  = s.stamp - prev_stamp;   // wraps at the timestamp width
         dt    = 64'(dt32);
         sum_v = longint'(prev_speed) + longint'(s.speed);
         neg   = (sum_v < 0);
         if (neg) mag = -sum_v;
         else     mag = sum_v;
         prod = mag * dt;
         // halving rounds toward minus infinity
         half = neg ? (prod >> 1) + prod[0] : (prod >> 1);
         if (neg) area = -longint'(half);
         else     area = half;
         dist_acc = dist_acc + area;
         if (dist_acc > DIST_MAX) dist_acc = DIST_MAX;
         if (dist_acc < DIST_MIN) dist_acc = DIST_MIN;

         dv = longint'(s.speed) - longint'(prev_speed);
         if (dv < 0) dvmag = -dv;
         else        dvmag = dv;
         if (dt == 0) begin
            accel      = ACCEL_MAX;
            r.zero_int = 1'b1;
         end else begin
            accel = (dvmag << FRAC_W) / dt;
            if (accel > ACCEL_MAX) accel = ACCEL_MAX;
         end
         if (accel > peak_hold) peak_hold = accel;
      end
      prev_speed = s.speed;
      prev_stamp = s.stamp;
      trip_open  = 1'b1;
      r.distance = dist_acc[DIST_W-1:0];
      r.peak     = peak_hold[PEAK_W-1:0];
      return r;
   endfunction

   function automatic void queue_sample(input bit start, input logic signed [SPEED_W-1:0] speed,
                                        input logic [TIME_W-1:0] stamp, input bit drain);
      speed_sample_type s;
      s.start       = start;
      s.speed       = speed;
      s.stamp       = stamp;
      s.drain_first = drain;
      pending_samples.push_back(s);
      stamp_now = stamp;
      speed_now = speed;
   endfunction

   // next speed: extremes, full range, small steps from the last one, near zero
   function automatic logic signed [SPEED_W-1:0] pick_speed();
      case ($urandom_range(0, 5))
         0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1:       return SPEED_W'(speed_now + $signed($urandom_range(0, 128)) - 64);
         2:       return SPEED_W'($signed($urandom_range(0, 2)) - 1);
         default: return SPEED_W'($urandom);
      endcase
   endfunction

   // time step: zero, short, medium, near full scale, anything
   function automatic logic [TIME_W-1:0] pick_gap();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return $urandom_range(1, 16);
         3, 4:    return $urandom_range(17, 65535);
         5:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Long trip at full speed and near full-scale dt, driving the distance onto
   // its bound, then one sample of the opposite sign to pull it off again.
   task automatic saturating_trip(input bit upward);
      queue_sample(1'b1, upward ? 16'sh7FFF : 16'sh8000, $urandom, 1'b0);
      repeat (SAT_RUN_LEN)
         queue_sample(1'b0,
                      upward ? SPEED_W'(16'sh7FFF - $urandom_range(0, 2))
                             : SPEED_W'(16'sh8000 + $urandom_range(0, 2)),
                      stamp_now + 32'hFFFF_FFFF - $urandom_range(0, 7), 1'b0);
      queue_sample(1'b0, upward ? 16'sh8000 : 16'sh7FFF, stamp_now + $urandom_range(1, 99),
                   1'b0);
   endtask

   // idling off in regular stretches and over the tail of the run
   function automatic bit idling_on(input int count);
      return (count < quiet_from) && ((count % 80) >= 20);
   endfunction

   // ------------------------------------------------------------------------
   // Driver: offers pending samples, predicts each one on its transfer.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_totals.push_back(advance_trip(offered));
            samples_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() == 0 ||
                         (pending_samples[0].drain_first && expected_totals.size() != 0)) begin
               // out of stimulus, or pausing until the block has emptied
               req_tvalid <= 1'b0;
            end else begin
               offered = pending_samples.pop_front();
               req_tdata  <= REQ_DATA_W'({offered.stamp, offered.speed});
               req_tuser  <= offered.start;
               req_tvalid <= 1'b1;
               if (idling_on(samples_taken) && $urandom_range(0, 2) == 0)
                  send_gap = $urandom_range(1, 17);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: checks each result transfer against the oldest expectation and
   // throttles rsp_tready, including one long hold-off to fill the block.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap  = 0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_totals.size() == 0) begin
               $error("unexpected result: distance_total %0d, peak_accel %0d",
                      $signed(rsp_tdata[DIST_W-1:0]), rsp_tdata[DIST_W+PEAK_W-1:DIST_W]);
               error_count++;
            end else begin
               want = expected_totals.pop_front();
               if (rsp_tdata[DIST_W-1:0] !== want.distance) begin
                  $error("distance_total: expected %0d, got %0d",
                         $signed(want.distance), $signed(rsp_tdata[DIST_W-1:0]));
                  error_count++;
               end
               if (rsp_tdata[DIST_W+PEAK_W-1:DIST_W] !== want.peak) begin
                  $error("peak_accel: expected %0d, got %0d",
                         want.peak, rsp_tdata[DIST_W+PEAK_W-1:DIST_W]);
                  error_count++;
               end
               if (rsp_tuser !== want.zero_int) begin
                  $error("zero_interval: expected %0d, got %0d", want.zero_int, rsp_tuser);
                  error_count++;
               end
            end
            results_seen++;
            if (results_seen == RX_HOLD_AT)
               hold_left = RX_HOLD_CYCLES;
            else if (idling_on(results_seen) && $urandom_range(0, 2) == 0)
               recv_gap = $urandom_range(1, 17);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (idling_on(results_seen) && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(0, 16);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog: too long without any transfer on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("trapezoid_distance_peak_accel_unit verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ------------------------------------------------------------------------
   initial begin
      bit sat_up_done;
      bit sat_down_done;
      int trip_len;
      sat_up_done   = 1'b0;
      sat_down_done = 1'b0;
      stamp_now     = '0;
      speed_now     = '0;

      // directed part
      queue_sample(1'b0, 16'sd100, 32'd1000, 1'b0);         // first after reset, no start
      queue_sample(1'b0, 16'sh8000, 32'd1005, 1'b0);
      queue_sample(1'b0, 16'sh7FFF, 32'd1005, 1'b0);         // zero interval
      queue_sample(1'b0, 16'sh7FFF, 32'hFFFF_FFF0, 1'b0);
      queue_sample(1'b0, 16'sh8000, 32'h0000_0010, 1'b0);    // timestamp wraps
      queue_sample(1'b1, -16'sd1, 32'h0000_0000, 1'b0);      // start mid-trip
      queue_sample(1'b0, 16'sd2, 32'd1, 1'b0);               // odd positive area
      queue_sample(1'b0, -16'sd5, 32'd2, 1'b0);              // odd negative area, floor
      queue_sample(1'b0, 16'sh7FFF, 32'd3, 1'b0);
      queue_sample(1'b0, 16'sh8000, 32'd4, 1'b0);            // largest dv over one tick
      queue_sample(1'b0, 16'sh7FFF, 32'd4, 1'b0);
      queue_sample(1'b1, 16'sh7FFF, 32'h8000_0000, 1'b1);    // start on an empty block
      queue_sample(1'b1, 16'sd0, 32'h8000_0000, 1'b0);       // two starts in a row
      queue_sample(1'b0, 16'sh7FFF, 32'h7FFF_FFFF, 1'b0);    // dt all ones
      queue_sample(1'b0, 16'sh7FFF, 32'h7FFF_FFFE, 1'b0);    // largest positive area
      queue_sample(1'b0, 16'sd0, 32'h7FFF_FFFF, 1'b0);
      queue_sample(1'b1, 16'sh8000, 32'h0000_0000, 1'b0);
      queue_sample(1'b0, 16'sh8000, 32'hFFFF_FFFF, 1'b0);    // largest negative area
      queue_sample(1'b0, 16'sd0, 32'hFFFF_FFFF, 1'b0);       // zero interval with dv
      queue_sample(1'b0, 16'sh7FFF, 32'hFFFF_FFFF, 1'b1);

      // random part: mostly well-formed trips, some stray samples, two trips
      // long enough to drive the distance onto each bound
      while (pending_samples.size() < 640) begin
         if (!sat_up_done && pending_samples.size() > 100) begin
            saturating_trip(1'b1);
            sat_up_done = 1'b1;
         end else if (!sat_down_done && pending_samples.size() > 380) begin
            saturating_trip(1'b0);
            sat_down_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            queue_sample(1'($urandom_range(0, 1)), SPEED_W'($urandom), $urandom, 1'b0);
         end else begin
            queue_sample(1'b1, pick_speed(), $urandom, 1'b0);
            trip_len = $urandom_range(1, 15);
            repeat (trip_len)
               queue_sample(1'b0, pick_speed(), stamp_now + pick_gap(),
                            pending_samples.size() > 60 && $urandom_range(0, 49) == 0);
         end
      end

      total_samples = pending_samples.size();
      quiet_from    = total_samples - TAIL_ITEMS;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (samples_taken < total_samples) @(posedge clock);
      while (expected_totals.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);   // catch any stray result after the last one

      if (error_count == 0)
         $display("trapezoid_distance_peak_accel_unit verification clean");
      else
         $display("trapezoid_distance_peak_accel_unit verification failed");
      $finish;
   end

endmodule
